@@ rtl/core/tsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants for the TLV stream deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

    localparam logic [7:0] ESCAPE_LEN = 8'hff;
    localparam logic [2:0] HDR_SHORT  = 3'd2;
    localparam logic [2:0] HDR_EXT    = 3'd6;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  msg_type;
        logic [31:0] msg_length;
        logic [7:0]  data_byte;
        logic [31:0] byte_index;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/tsd_front.sv @@
// ----------------------------------------------------------------------------
// tsd_front
// Header parser: takes stream bytes, tracks the message phase and builds
// one result record per header completion or payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_front
    import tsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_take,
    input  wire logic [7:0] i_byte,
    output logic         o_push,
    output t_result      o_result
);

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_EXTLEN  = 2'd1,
        ST_PAYLOAD = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hcount, n_hcount;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_length, n_length;
    logic [31:0] r_pcount, n_pcount;

    logic        v_push;
    logic        v_finish;
    logic [1:0]  v_pos;
    logic [31:0] v_idx_next;

    always_comb begin
        n_phase    = r_phase;
        n_hcount   = r_hcount;
        n_type     = r_type;
        n_length   = r_length;
        n_pcount   = r_pcount;
        v_push     = 1'b0;
        v_finish   = 1'b0;
        v_pos      = 2'(r_hcount - HDR_SHORT);
        v_idx_next = r_pcount + 32'd1;
        o_result   = '0;
        unique case (r_phase)
            ST_EXTLEN: begin
                n_length = r_length | (32'(i_byte) << {v_pos, 3'b000});
                n_hcount = r_hcount + 3'd1;
                if (n_hcount >= HDR_EXT || n_hcount < HDR_SHORT) begin
                    v_finish = 1'b1;
                end
            end
            ST_PAYLOAD: begin
                v_push              = 1'b1;
                o_result.kind       = KIND_PAYLOAD;
                o_result.msg_type   = r_type;
                o_result.msg_length = r_length;
                o_result.data_byte  = i_byte;
                o_result.byte_index = r_pcount;
                o_result.last       = (v_idx_next == r_length);
                n_pcount            = v_idx_next;
                if (v_idx_next == r_length) begin
                    n_phase  = ST_HEADER;
                    n_hcount = 3'd0;
                    n_pcount = 32'd0;
                end
            end
            default: begin
                n_phase = ST_HEADER;
                if (r_hcount == 3'd0) begin
                    n_type   = i_byte;
                    n_hcount = 3'd1;
                end else if (i_byte == ESCAPE_LEN) begin
                    n_phase  = ST_EXTLEN;
                    n_hcount = HDR_SHORT;
                    n_length = 32'd0;
                end else begin
                    n_length = 32'(i_byte);
                    v_finish = 1'b1;
                end
            end
        endcase
        if (v_finish) begin
            v_push              = 1'b1;
            o_result.kind       = KIND_HEADER;
            o_result.msg_type   = n_type;
            o_result.msg_length = n_length;
            o_result.data_byte  = 8'd0;
            o_result.byte_index = 32'd0;
            o_result.last       = (n_length == 32'd0);
            n_hcount            = 3'd0;
            n_pcount            = 32'd0;
            n_phase             = (n_length == 32'd0) ? ST_HEADER : ST_PAYLOAD;
        end
    end

    assign o_push = i_take & v_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ST_HEADER;
            r_hcount <= 3'd0;
            r_type   <= 8'd0;
            r_length <= 32'd0;
            r_pcount <= 32'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_type   <= n_type;
            r_length <= n_length;
            r_pcount <= n_pcount;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tsd_queue.sv @@
// ----------------------------------------------------------------------------
// tsd_queue
// Short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_queue
    import tsd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output t_result      o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tlv_stream_deframer_top.sv @@
// ----------------------------------------------------------------------------
// tlv_stream_deframer_top
// Splits a byte stream into type-length-value messages and emits header
// and payload results.
//
//  Channel | Direction | Word content
//  --------+-----------+--------------------------------------------------
//  s       | in        | one stream byte
//  m       | out       | header result or payload byte with type/length
//
// One byte is accepted per cycle while the result queue has room.
// A result is built combinationally from its byte and registered in the queue.
// The queue of QUEUE_DEPTH entries absorbs output stalls; input stalls only
// when it is full.
// Reset clears the parser state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_stream_deframer_top
    import tsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // in_byte[7:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata,   // msg_type, msg_length, data_byte, byte_index
    output logic [0:0]       o_m_tuser,   // kind
    output logic             o_m_tlast
);

    logic    w_take;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_result w_front_res;
    t_result w_head;

    assign o_s_tready = !w_full;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = !w_empty;
    assign w_pop      = o_m_tvalid && i_m_tready;

    tsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_byte   (i_s_tdata),
        .o_push   (w_push),
        .o_result (w_front_res)
    );

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign o_m_tdata = {w_head.byte_index, w_head.data_byte,
                        w_head.msg_length, w_head.msg_type};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

    a_empty_hdr_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_head.kind == KIND_HEADER && w_head.msg_length == 32'd0)
        |-> o_m_tlast)
        else $error("zero-length header not marked last");

    a_payload_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_head.kind == KIND_PAYLOAD)
        |-> (o_m_tlast == (w_head.byte_index + 32'd1 == w_head.msg_length)))
        else $error("payload last mark does not match index and length");

    a_hdr_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_head.kind == KIND_HEADER)
        |-> (w_head.data_byte == 8'd0 && w_head.byte_index == 32'd0))
        else $error("header result carries payload fields");

endmodule

`default_nettype wire

@@ tb/sv/tlv_stream_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// tlv_stream_deframer_checker
// Watches both stream channels of the TLV deframer, predicts the header and
// payload results from the accepted bytes, and compares every word that
// leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_checker
    import tsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte[7:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // msg_type, msg_length, data_byte, byte_index
    input  logic [0:0]  i_m_tuser,   // kind
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXT_LEN = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SPARE   = 2'd3
    } t_parse_phase;

    t_parse_phase parse_phase;
    logic [2:0]   hdr_count;
    logic [7:0]   cur_type;
    logic [31:0]  cur_length;
    logic [31:0]  payload_seen;
    t_result      pending_results[$];
    int           mismatch_count;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_result make_result(input logic kind, input logic [7:0] data,
                                            input logic [31:0] index, input logic last);
        t_result r;
        r.kind       = kind;
        r.msg_type   = cur_type;
        r.msg_length = cur_length;
        r.data_byte  = data;
        r.byte_index = index;
        r.last       = last;
        return r;
    endfunction

    function automatic t_result close_header();
        t_result r;
        r = make_result(KIND_HEADER, 8'd0, 32'd0, cur_length == 32'd0);
        hdr_count    = 3'd0;
        payload_seen = 32'd0;
        parse_phase  = (cur_length == 32'd0) ? PH_HEADER : PH_PAYLOAD;
        return r;
    endfunction

    // Advances the parser by one stream byte; returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [2:0]  pos;
        logic        ends;
        r = '0;
        if (parse_phase == PH_EXT_LEN) begin
            pos = hdr_count - HDR_SHORT;
            cur_length = cur_length | (32'(b) << (8 * pos[1:0]));
            hdr_count  = hdr_count + 3'd1;
            if (hdr_count >= HDR_EXT || hdr_count < HDR_SHORT) begin
                r = close_header();
                return 1'b1;
            end
            return 1'b0;
        end
        if (parse_phase == PH_PAYLOAD) begin
            ends = (payload_seen + 32'd1 == cur_length);
            r = make_result(KIND_PAYLOAD, b, payload_seen, ends);
            payload_seen = payload_seen + 32'd1;
            if (ends) begin
                parse_phase  = PH_HEADER;
                hdr_count    = 3'd0;
                payload_seen = 32'd0;
            end
            return 1'b1;
        end
        parse_phase = PH_HEADER;
        if (hdr_count == 3'd0) begin
            cur_type  = b;
            hdr_count = 3'd1;
            return 1'b0;
        end
        if (b == ESCAPE_LEN) begin
            parse_phase = PH_EXT_LEN;
            hdr_count   = HDR_SHORT;
            cur_length  = 32'd0;
            return 1'b0;
        end
        cur_length = 32'(b);
        r = close_header();
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result predicted;
        t_result observed;
        if (!i_rst_n) begin
            parse_phase    = PH_HEADER;
            hdr_count      = 3'd0;
            cur_type       = 8'd0;
            cur_length     = 32'd0;
            payload_seen   = 32'd0;
            mismatch_count = 0;
            pending_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (deframe_byte(i_s_tdata, predicted)) begin
                    pending_results.push_back(predicted);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                observed.kind       = i_m_tuser[0];
                observed.msg_type   = i_m_tdata[7:0];
                observed.msg_length = i_m_tdata[39:8];
                observed.data_byte  = i_m_tdata[47:40];
                observed.byte_index = i_m_tdata[79:48];
                observed.last       = i_m_tlast;
                if (pending_results.size() == 0) begin
                    $error("Unexpected word on the master side: 0x%0h", i_m_tdata);
                    mismatch_count++;
                end else begin
                    predicted = pending_results.pop_front();
                    compare_field("kind", 32'(predicted.kind), 32'(observed.kind));
                    compare_field("msg_type", 32'(predicted.msg_type),
                                  32'(observed.msg_type));
                    compare_field("msg_length", predicted.msg_length, observed.msg_length);
                    compare_field("data_byte", 32'(predicted.data_byte),
                                  32'(observed.data_byte));
                    compare_field("byte_index", predicted.byte_index, observed.byte_index);
                    compare_field("last", 32'(predicted.last), 32'(observed.last));
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= pending_results.size();
    end

endmodule

@@ tb/sv/tlv_stream_deframer_top_test.sv @@
// ----------------------------------------------------------------------------
// tlv_stream_deframer_top_test
// Feeds the TLV deframer a byte stream of short-length, extended-length and
// zero-length messages mixed with stray bytes, under varying idle patterns
// on both channels, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_top_test;
    import tsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    int errors;
    int pending;
    int words_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;

    tlv_stream_deframer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    tlv_stream_deframer_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #2_000_000ns;
        $display("FAIL tlv_stream_deframer_top");
        $finish;
    end

    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg_type, input logic [31:0] len,
                                input bit extended, input int payload_words);
        send_word(msg_type);
        if (extended) begin
            send_word(ESCAPE_LEN);
            for (int i = 0; i < 4; i++) send_word(len[8*i +: 8]);
        end else begin
            send_word(len[7:0]);
        end
        for (int i = 0; i < payload_words; i++) send_word(8'($urandom));
    endtask

    task automatic send_random_message();
        int          sel;
        int unsigned len;
        sel = $urandom_range(99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom));
        end else if (sel < 70) begin
            len = $urandom_range(15);
            send_message(8'($urandom), len, 1'b0, len);
        end else if (sel < 80) begin
            len = $urandom_range(16, 254);
            send_message(8'($urandom), len, 1'b0, len);
        end else begin
            len = ($urandom_range(9) == 0) ? 255 : $urandom_range(40);
            send_message(8'($urandom), len, 1'b1, len);
        end
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [31:0] huge_len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 37;
        rx_idle_pct = 52;
        send_message(8'h00, 32'd0, 1'b0, 0);
        send_word(8'hff);
        send_word(8'h01);
        send_word(8'hff);
        send_word(8'ha5);
        send_word(8'h03);
        send_word(8'h00);
        send_word(8'hff);
        send_word(8'h5a);
        send_message(8'h11, 32'd0, 1'b1, 0);
        send_word(8'h22);
        send_word(8'hff);
        send_word(8'h02);
        send_word(8'h00);
        send_word(8'h00);
        send_word(8'h00);
        send_word(8'h81);
        send_word(8'h7e);

        while (words_sent < 300) send_random_message();
        i_s_tvalid <= 1'b0;
        drain_results();

        tx_idle_pct = 52;
        rx_idle_pct = 37;
        while (words_sent < 600) send_random_message();
        i_s_tvalid <= 1'b0;
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (words_sent < 900) send_random_message();
        huge_len = {8'($urandom_range(128, 255)), 24'($urandom)};
        send_message(8'($urandom), huge_len, 1'b1, 5);
        i_s_tvalid <= 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS tlv_stream_deframer_top");
        end else begin
            $display("FAIL tlv_stream_deframer_top");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tsd_pkg.sv
rtl/core/tsd_front.sv
rtl/core/tsd_queue.sv
rtl/core/tlv_stream_deframer_top.sv
tb/sv/tlv_stream_deframer_checker.sv
tb/sv/tlv_stream_deframer_top_test.sv
